### rtl/core/assert_macros.svh
// Assertion macros used by the list engine module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLOCKED(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

### rtl/core/sale_pkg.sv
// Package with the command, status and cell control definitions of the list engine.
`default_nettype none

package sale_pkg;

   localparam int AT_WIDTH = 11;

   localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [2:0] CMD_POP_BACK   = 3'd1;
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [2:0] CMD_INSERT     = 3'd4;
   localparam logic [2:0] CMD_ERASE      = 3'd5;
   localparam logic [2:0] CMD_FIND       = 3'd6;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [1:0] STATUS_BADPOS = 2'd3;

   localparam logic [1:0] OP_HOLD  = 2'd0;
   localparam logic [1:0] OP_OPEN  = 2'd1;
   localparam logic [1:0] OP_CLOSE = 2'd2;
   localparam logic [1:0] OP_MATCH = 2'd3;

   typedef struct packed {
      logic [1:0]          op;
      logic [AT_WIDTH-1:0] at;
      logic [AT_WIDTH-1:0] limit;
   } cell_ctl_type;

endpackage

`default_nettype wire

### rtl/core/shifting_array_list_engine.sv
// Ordered list engine: push, pop, insert and erase items shift a row of cells; find searches it.
// Push, pop, insert, erase and unused commands: result strobe in the cycle after the accepting
// edge, and a new item may be accepted in every cycle while no find holds the engine busy.
// Find: the engine stays busy for a span set by the depth of the registered priority tree; the
// result strobe is registered once the tree root holds the lowest matching index.
// Reset clears the element count and the control state; cell contents stay undefined.
`default_nettype none

module shifting_array_list_engine #(
   parameter int CAPACITY   = 128,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic        [2:0]  req_command,
   input  wire logic        [7:0]  req_position,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_strobe,
   output logic             [1:0]  rsp_status,
   output logic                    rsp_found,
   output logic             [6:0]  rsp_found_index,
   output logic             [7:0]  rsp_count_after
);

   `include "assert_macros.svh"

   localparam int AW          = sale_pkg::AT_WIDTH;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int LEVELS      = $clog2(CAPACITY);
   localparam int WAIT_WIDTH  = $clog2(LEVELS + 1);
   localparam int CNT_EXT     = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
   localparam int IDX_EXT     = (LEVELS > 7) ? LEVELS : 7;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_FIND = 1'b1;

   logic                   state_ff;
   logic                   state_in;
   logic [WAIT_WIDTH-1:0]  wait_ff;
   logic [WAIT_WIDTH-1:0]  wait_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_strobe_ff;
   logic                   rsp_strobe_in;
   logic [1:0]             rsp_status_ff;
   logic                   rsp_found_ff;
   logic [6:0]             rsp_found_index_ff;
   logic [7:0]             rsp_count_after_ff;

   logic                   accept;
   logic                   find_done;
   logic                   is_full;
   logic                   is_empty;
   logic [AW-1:0]          count_at;
   logic [AW-1:0]          pos_at;
   logic [1:0]             status_w;
   logic signed [63:0]     value_ext;
   logic [DATA_WIDTH-1:0]  key;
   logic [CNT_EXT-1:0]     count_ext;
   logic [IDX_EXT-1:0]     idx_ext;
   sale_pkg::cell_ctl_type ctl;

   logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];
   logic [CAPACITY-1:0]    cell_hit;
   logic                   root_hit;
   logic [LEVELS-1:0]      root_idx;

   assign busy      = (state_ff == S_FIND);
   assign accept    = start && !busy;
   assign find_done = (state_ff == S_FIND) && (wait_ff == '0);
   assign is_full   = (count_ff == COUNT_WIDTH'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign count_at  = AW'(count_ff);
   assign pos_at    = AW'(req_position);
   assign value_ext = 64'(req_value);
   assign key       = value_ext[DATA_WIDTH-1:0];

   always_comb begin
      ctl.op    = sale_pkg::OP_HOLD;
      ctl.at    = '0;
      ctl.limit = count_at;
      status_w  = sale_pkg::STATUS_OK;
      count_in  = count_ff;
      if (accept) begin
         case (req_command)
            sale_pkg::CMD_PUSH_BACK, sale_pkg::CMD_PUSH_FRONT, sale_pkg::CMD_INSERT: begin
               if (is_full) begin
                  status_w = sale_pkg::STATUS_FULL;
               end else if ((req_command == sale_pkg::CMD_INSERT) && (pos_at > count_at)) begin
                  status_w = sale_pkg::STATUS_BADPOS;
               end else begin
                  ctl.op = sale_pkg::OP_OPEN;
                  if (req_command == sale_pkg::CMD_PUSH_BACK) begin
                     ctl.at = count_at;
                  end else if (req_command == sale_pkg::CMD_INSERT) begin
                     ctl.at = pos_at;
                  end
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
            end
            sale_pkg::CMD_POP_BACK, sale_pkg::CMD_POP_FRONT, sale_pkg::CMD_ERASE: begin
               if (is_empty) begin
                  status_w = sale_pkg::STATUS_EMPTY;
               end else if ((req_command == sale_pkg::CMD_ERASE) && (pos_at >= count_at)) begin
                  status_w = sale_pkg::STATUS_BADPOS;
               end else begin
                  ctl.op = sale_pkg::OP_CLOSE;
                  if (req_command == sale_pkg::CMD_POP_BACK) begin
                     ctl.at = count_at - AW'(1);
                  end else if (req_command == sale_pkg::CMD_ERASE) begin
                     ctl.at = pos_at;
                  end
                  count_in = count_ff - COUNT_WIDTH'(1);
               end
            end
            sale_pkg::CMD_FIND: begin
               ctl.op = sale_pkg::OP_MATCH;
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_w;
      logic [DATA_WIDTH-1:0] upper_w;

      if (i == 0) begin : g_first
         assign lower_w = '0;
      end else begin : g_lower
         assign lower_w = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign upper_w = '0;
      end else begin : g_upper
         assign upper_w = cell_data[i+1];
      end

      sale_cell #(
         .DATA_WIDTH(DATA_WIDTH),
         .INDEX     (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .key       (key),
         .lower_data(lower_w),
         .upper_data(upper_w),
         .data      (cell_data[i]),
         .hit       (cell_hit[i])
      );
   end

   sale_find_tree #(
      .LEAVES(CAPACITY)
   ) u_find_tree (
      .clock   (clock),
      .leaf_hit(cell_hit),
      .root_hit(root_hit),
      .root_idx(root_idx)
   );

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_command == sale_pkg::CMD_FIND)) begin
               state_in = S_FIND;
               wait_in  = WAIT_WIDTH'(LEVELS);
            end
         end
         S_FIND: begin
            if (wait_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               wait_in = wait_ff - WAIT_WIDTH'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_strobe_in = (accept && (req_command != sale_pkg::CMD_FIND)) || find_done;
   assign count_ext     = CNT_EXT'(count_in);
   assign idx_ext       = IDX_EXT'(root_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wait_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wait_ff       <= wait_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (find_done) begin
         rsp_status_ff      <= sale_pkg::STATUS_OK;
         rsp_found_ff       <= root_hit;
         rsp_found_index_ff <= idx_ext[6:0];
         rsp_count_after_ff <= count_ext[7:0];
      end else if (accept) begin
         rsp_status_ff      <= status_w;
         rsp_found_ff       <= 1'b0;
         rsp_found_index_ff <= '0;
         rsp_count_after_ff <= count_ext[7:0];
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_found_index_ff;
   assign rsp_count_after = rsp_count_after_ff;

   `ASSERT_ALWAYS(a_count_in_range, clock, reset, count_ff <= COUNT_WIDTH'(CAPACITY), "count exceeds capacity")
   `ASSERT_CLOCKED(a_plain_result, clock, reset, (accept && (req_command != sale_pkg::CMD_FIND)) |=> rsp_strobe, "missing result after a plain item")
   `ASSERT_CLOCKED(a_find_busy, clock, reset, (accept && (req_command == sale_pkg::CMD_FIND)) |=> (busy && !rsp_strobe), "find did not occupy the engine")
   `ASSERT_CLOCKED(a_reject_keeps, clock, reset, (rsp_strobe && (rsp_status != sale_pkg::STATUS_OK)) |-> (count_ff == $past(count_ff)), "rejected item changed the count")
   `ASSERT_CLOCKED(a_found_nonempty, clock, reset, (rsp_strobe && rsp_found) |-> (count_ff != '0), "key found in an empty list")

endmodule

`default_nettype wire

### rtl/core/sale_cell.sv
// One list cell: holds an element, shifts with its neighbours and compares against a key.
`default_nettype none

module sale_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int INDEX      = 0
) (
   input  wire logic                  clock,
   input  wire sale_pkg::cell_ctl_type ctl,
   input  wire logic [DATA_WIDTH-1:0] key,
   input  wire logic [DATA_WIDTH-1:0] lower_data,
   input  wire logic [DATA_WIDTH-1:0] upper_data,
   output logic      [DATA_WIDTH-1:0] data,
   output logic                       hit
);

   localparam logic [sale_pkg::AT_WIDTH-1:0] MY_INDEX = sale_pkg::AT_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  hit_ff;
   logic                  hit_in;

   always_comb begin
      data_in = data_ff;
      hit_in  = hit_ff;
      case (ctl.op)
         sale_pkg::OP_OPEN: begin
            if (MY_INDEX > ctl.at) begin
               data_in = lower_data;
            end else if (MY_INDEX == ctl.at) begin
               data_in = key;
            end
         end
         sale_pkg::OP_CLOSE: begin
            if (MY_INDEX >= ctl.at) begin
               data_in = upper_data;
            end
         end
         sale_pkg::OP_MATCH: begin
            hit_in = (MY_INDEX < ctl.limit) && (data_ff == key);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

`default_nettype wire

### rtl/core/sale_find_tree.sv
// Registered priority tree that reports the lowest cell index whose hit flag is set.
`default_nettype none

module sale_find_tree #(
   parameter int LEAVES = 128
) (
   input  wire logic                         clock,
   input  wire logic [LEAVES-1:0]            leaf_hit,
   output logic                              root_hit,
   output logic      [$clog2(LEAVES)-1:0]    root_idx
);

   localparam int LEVELS = $clog2(LEAVES);
   localparam int SPAN   = 1 << LEVELS;

   logic              node_hit [2*SPAN-1];
   logic [LEVELS-1:0] node_idx [2*SPAN-1];

   for (genvar j = 0; j < SPAN; j++) begin : g_leaf
      if (j < LEAVES) begin : g_real
         assign node_hit[SPAN-1+j] = leaf_hit[j];
      end else begin : g_pad
         assign node_hit[SPAN-1+j] = 1'b0;
      end
      assign node_idx[SPAN-1+j] = LEVELS'(j);
   end

   for (genvar n = 0; n < SPAN-1; n++) begin : g_node
      logic              hit_ff;
      logic              hit_in;
      logic [LEVELS-1:0] idx_ff;
      logic [LEVELS-1:0] idx_in;

      always_comb begin
         hit_in = node_hit[2*n+1] | node_hit[2*n+2];
         if (node_hit[2*n+1]) begin
            idx_in = node_idx[2*n+1];
         end else if (node_hit[2*n+2]) begin
            idx_in = node_idx[2*n+2];
         end else begin
            idx_in = '0;
         end
      end

      always_ff @(posedge clock) begin
         hit_ff <= hit_in;
         idx_ff <= idx_in;
      end

      assign node_hit[n] = hit_ff;
      assign node_idx[n] = idx_ff;
   end

   assign root_hit = node_hit[0];
   assign root_idx = node_idx[0];

endmodule

`default_nettype wire
